/* sv/mpc_pkg.sv */
// ----------------------------------------------------------------------------
// mpc_pkg: shared definitions for the permutation count block
// Holds the modulus, the Fermat exponent, the letter alphabet size, the
// sequencer state encoding and the histogram control bundle.
// ----------------------------------------------------------------------------
package mpc_pkg;

    // Result width and the prime modulus (fits in 30 bits).
    localparam int RES_W = 30;
    localparam logic [RES_W-1:0] PRIME_MOD = 30'd1000000007;

    // Exponent p-2 for inversion by Fermat's little theorem.
    localparam logic [RES_W-1:0] FERMAT_EXP = 30'd1000000005;
    localparam int EXP_BIT_W = $clog2(RES_W);

    // Letter codes 0..25 are counted, anything above is ignored.
    localparam int LETTER_W = 5;
    localparam int LETTER_COUNT = 26;
    localparam int IDX_W = $clog2(LETTER_COUNT + 1);

    // One multiplier bit is consumed per cycle by the modular multiplier.
    localparam int MUL_STEPS = RES_W;
    localparam int MUL_STEP_W = $clog2(MUL_STEPS);

    // Default limit on the string length.
    localparam int MAX_LEN_DEF = 65536;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_NUM,
        ST_DEN,
        ST_POW,
        ST_FINAL,
        ST_OUT
    } state_t;

    // Control from the sequencer to the histogram.
    typedef struct packed {
        logic count_en;
        logic clear;
    } hist_ctrl_t;

endpackage

/* sv/mpc_modmul.sv */
// ----------------------------------------------------------------------------
// mpc_modmul: shared modular multiplier
// Interleaved shift-and-add multiplication modulo the prime. One bit of the
// multiplier is consumed per cycle, most significant first; the product is
// presented with a one-cycle done pulse after the last step.
// ----------------------------------------------------------------------------
module mpc_modmul
    import mpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [RES_W-1:0] op_a,
    input  logic [RES_W-1:0] op_b,
    output logic             done,
    output logic [RES_W-1:0] product
);

    localparam logic [RES_W:0] MOD_EXT = {1'b0, PRIME_MOD};

    logic                  busy_reg;
    logic                  done_reg;
    logic [MUL_STEP_W-1:0] step_reg;
    logic [RES_W-1:0]      a_reg;
    logic [RES_W-1:0]      b_reg;
    logic [RES_W-1:0]      r_reg;

    logic [RES_W:0]   dbl;
    logic [RES_W:0]   dbl_red;
    logic [RES_W:0]   sum;
    logic [RES_W:0]   sum_red;
    logic [RES_W-1:0] r_next;

    // One step: double the partial result, then add the multiplicand if the
    // current multiplier bit is set, reducing after each operation.
    always_comb begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= MOD_EXT) ? dbl - MOD_EXT : dbl;
        sum     = dbl_red + (b_reg[RES_W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= MOD_EXT) ? sum - MOD_EXT : sum;
        r_next  = sum_red[RES_W-1:0];
    end

    // Step control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= MUL_STEP_W'(MUL_STEPS - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
            r_reg <= '0;
        end else if (busy_reg) begin
            b_reg <= {b_reg[RES_W-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

/* sv/mpc_hist.sv */
// ----------------------------------------------------------------------------
// mpc_hist: letter histogram and length counter
// Counts each accepted letter in its own counter, tracks the string length
// and flags a string that runs past the length limit. One counter is read
// back at a time for the denominator pass.
// ----------------------------------------------------------------------------
module mpc_hist
    import mpc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hist_ctrl_t                      ctrl,
    input  logic [LETTER_W-1:0]             letter,
    input  logic [IDX_W-1:0]                rd_idx,
    output logic [$clog2(MAX_LEN+1)-1:0]    rd_count,
    output logic [$clog2(MAX_LEN+1)-1:0]    length,
    output logic                            exceeded_upd
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [LEN_W-1:0] count_reg [LETTER_COUNT];
    logic [LEN_W-1:0] length_reg;
    logic             exceeded_reg;

    logic in_range;
    logic full;
    logic bump;

    // A valid letter is counted unless the limit is already reached.
    always_comb begin
        in_range     = (letter < LETTER_W'(LETTER_COUNT));
        full         = (length_reg == LEN_W'(MAX_LEN));
        bump         = ctrl.count_en && in_range && !full;
        exceeded_upd = exceeded_reg || (ctrl.count_en && in_range && full);
    end

    // Counters, cleared together after each result.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int i = 0; i < LETTER_COUNT; i++) begin
                count_reg[i] <= '0;
            end
            length_reg   <= '0;
            exceeded_reg <= 1'b0;
        end else begin
            for (int i = 0; i < LETTER_COUNT; i++) begin
                if (bump && (letter == LETTER_W'(i))) begin
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
            end
            if (bump) begin
                length_reg <= length_reg + 1'b1;
            end
            exceeded_reg <= exceeded_upd;
        end
    end

    // Read port for the denominator pass; past the last letter reads zero.
    always_comb begin
        if (rd_idx < IDX_W'(LETTER_COUNT)) begin
            rd_count = count_reg[rd_idx[LETTER_W-1:0]];
        end else begin
            rd_count = '0;
        end
    end

    assign length = length_reg;

endmodule

/* sv/multinomial_permutation_count_mod.sv */
// Letters are taken one per cycle while the block is collecting; s_ready is low
// while a result is computed or handed out. After the last letter every modular
// product of the result, through the histogram scan and the exponent walk, goes
// through one bit-serial multiplier. An overflowed string goes straight to the
// output state and its result is then registered in the output register, where a result waits until taken.
// Synchronous active-low reset clears the histogram, length and the control registers.
// ----------------------------------------------------------------------------
// multinomial_permutation_count_mod: distinct arrangement counter
// Builds a letter histogram, then computes n! / prod(c_i!) modulo the prime
// with a small sequencer around one shared modular multiplier.
// ----------------------------------------------------------------------------
module multinomial_permutation_count_mod
    import mpc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [LETTER_W-1:0] s_letter,
    input  logic                s_last_letter,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RES_W-1:0]    m_arrangements,
    output logic                m_overflow
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int CNT_W = $clog2(MAX_LEN + 2);

    state_t state_reg, state_next;

    logic                 wait_reg, wait_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [EXP_BIT_W-1:0] bit_reg, bit_next;
    logic                 phase_reg, phase_next;
    logic [RES_W-1:0]     num_reg, num_next;
    logic [RES_W-1:0]     den_reg, den_next;
    logic [RES_W-1:0]     base_reg, base_next;
    logic [RES_W-1:0]     pow_reg, pow_next;
    logic [RES_W-1:0]     res_reg, res_next;
    logic                 ovf_reg, ovf_next;
    logic                 m_valid_reg, m_valid_next;
    logic [RES_W-1:0]     m_arr_reg, m_arr_next;
    logic                 m_ovf_reg, m_ovf_next;

    logic             accept;
    logic             out_free;
    hist_ctrl_t       hist_ctrl;
    logic [LEN_W-1:0] hist_count;
    logic [LEN_W-1:0] str_len;
    logic             exceeded_upd;
    logic             mul_start;
    logic [RES_W-1:0] mul_a;
    logic [RES_W-1:0] mul_b;
    logic             mul_done;
    logic [RES_W-1:0] mul_prod;

    // Handshake.
    assign s_ready  = (state_reg == ST_COLLECT);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign hist_ctrl.count_en = accept;
    assign hist_ctrl.clear    = (state_reg == ST_OUT) && out_free;

    mpc_hist #(
        .MAX_LEN (MAX_LEN)
    ) u_hist (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (hist_ctrl),
        .letter       (s_letter),
        .rd_idx       (idx_reg),
        .rd_count     (hist_count),
        .length       (str_len),
        .exceeded_upd (exceeded_upd)
    );

    mpc_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (accept && s_last_letter) begin
                    state_next = exceeded_upd ? ST_OUT : ST_NUM;
                end
            end
            ST_NUM: begin
                if (!wait_reg && (cnt_reg > CNT_W'(str_len))) begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN: begin
                if (!wait_reg && (idx_reg == IDX_W'(LETTER_COUNT))) begin
                    state_next = ST_POW;
                end
            end
            ST_POW: begin
                if (!wait_reg && phase_reg && (bit_reg == EXP_BIT_W'(RES_W - 1))) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (mul_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // Datapath and multiplier requests per state.
    always_comb begin
        wait_next    = wait_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        bit_next     = bit_reg;
        phase_next   = phase_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        base_next    = base_reg;
        pow_next     = pow_reg;
        res_next     = res_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_arr_next   = m_arr_reg;
        m_ovf_next   = m_ovf_reg;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_COLLECT: begin
                // The last request starts the computation or reports overflow.
                if (accept && s_last_letter) begin
                    num_next = RES_W'(1);
                    cnt_next = CNT_W'(2);
                    ovf_next = exceeded_upd;
                    res_next = '0;
                end
            end
            ST_NUM: begin
                // n! as a running product of 2..n.
                if (mul_done) begin
                    num_next  = mul_prod;
                    cnt_next  = cnt_reg + 1'b1;
                    wait_next = 1'b0;
                end else if (!wait_reg) begin
                    if (cnt_reg <= CNT_W'(str_len)) begin
                        mul_start = 1'b1;
                        mul_a     = num_reg;
                        mul_b     = RES_W'(cnt_reg);
                        wait_next = 1'b1;
                    end else begin
                        idx_next = '0;
                        cnt_next = CNT_W'(2);
                        den_next = RES_W'(1);
                    end
                end
            end
            ST_DEN: begin
                // Product of the letter-count factorials, one letter at a time.
                if (mul_done) begin
                    den_next  = mul_prod;
                    cnt_next  = cnt_reg + 1'b1;
                    wait_next = 1'b0;
                end else if (!wait_reg) begin
                    if (idx_reg == IDX_W'(LETTER_COUNT)) begin
                        base_next  = den_reg;
                        pow_next   = RES_W'(1);
                        bit_next   = '0;
                        phase_next = 1'b0;
                    end else if (cnt_reg <= CNT_W'(hist_count)) begin
                        mul_start = 1'b1;
                        mul_a     = den_reg;
                        mul_b     = RES_W'(cnt_reg);
                        wait_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        cnt_next = CNT_W'(2);
                    end
                end
            end
            ST_POW: begin
                // Square-and-multiply over the exponent bits, least significant
                // first; the square after the top bit is not needed.
                if (mul_done) begin
                    if (!phase_reg) begin
                        pow_next   = mul_prod;
                        phase_next = 1'b1;
                    end else begin
                        base_next  = mul_prod;
                        phase_next = 1'b0;
                        bit_next   = bit_reg + 1'b1;
                    end
                    wait_next = 1'b0;
                end else if (!wait_reg) begin
                    if (!phase_reg) begin
                        if (FERMAT_EXP[bit_reg]) begin
                            mul_start = 1'b1;
                            mul_a     = pow_reg;
                            mul_b     = base_reg;
                            wait_next = 1'b1;
                        end else begin
                            phase_next = 1'b1;
                        end
                    end else if (bit_reg != EXP_BIT_W'(RES_W - 1)) begin
                        mul_start = 1'b1;
                        mul_a     = base_reg;
                        mul_b     = base_reg;
                        wait_next = 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                // Numerator times the inverted denominator.
                if (mul_done) begin
                    res_next  = mul_prod;
                    wait_next = 1'b0;
                end else if (!wait_reg) begin
                    mul_start = 1'b1;
                    mul_a     = num_reg;
                    mul_b     = pow_reg;
                    wait_next = 1'b1;
                end
            end
            ST_OUT: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_arr_next   = res_reg;
                    m_ovf_next   = ovf_reg;
                end
            end
            default: begin
                wait_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            wait_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Loop counters and payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        bit_reg   <= bit_next;
        phase_reg <= phase_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        base_reg  <= base_next;
        pow_reg   <= pow_next;
        res_reg   <= res_next;
        m_arr_reg <= m_arr_next;
        m_ovf_reg <= m_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_arrangements = m_arr_reg;
    assign m_overflow     = m_ovf_reg;

endmodule
